[sv/linear_probe_list_table_top_macros.svh]
// assertion macros for the list table
`ifndef LINEAR_PROBE_LIST_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_LIST_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define LPL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list table check failed");

// next-cycle implication
`define LPL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list table check failed");

`endif

[sv/lpl_pkg.sv]
// shared types and constants for the list table
package lpl_pkg;
  localparam int unsigned TABLE_SLOTS = 256;
  localparam int unsigned IDX_W = 8;
  localparam logic [15:0] MAX_COMMANDS = 16'hFFFF;

  localparam logic [2:0] CMD_NEW = 3'd0;
  localparam logic [2:0] CMD_END = 3'd1;
  localparam logic [2:0] CMD_CALL = 3'd2;
  localparam logic [2:0] CMD_DELETE = 3'd3;
  localparam logic [2:0] CMD_IS = 3'd4;
  localparam logic [2:0] CMD_RECORD = 3'd5;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_VALUE = 3'd1;
  localparam logic [2:0] ERR_OPERATION = 3'd2;
  localparam logic [2:0] ERR_ENUM = 3'd3;
  localparam logic [2:0] ERR_MEMORY = 3'd4;

  localparam logic [15:0] MODE_COMPILE = 16'h1300;
  localparam logic [15:0] MODE_COMPILE_EXEC = 16'h1301;

  typedef struct packed {
    logic        tomb;
    logic        used;
    logic [31:0] key;
  } slot_t;

  typedef struct packed {
    logic [2:0]       error;
    logic             found;
    logic             accepted;
    logic [IDX_W-1:0] slot_index;
    logic [IDX_W:0]   deleted_count;
    logic             is_recording;
  } res_t;
endpackage

[sv/linear_probe_list_table_top.sv]
// linear probing list table, top level with result register
// new_list probes from the key's home slot until a match or the last slot, call_list and
// is_list also stop at an empty untombed slot, delete_range walks all 256 slots
// one item at a time, the probe loop over the slot memory read port sets the rate
// a new item is taken while a finished result waits in the output register
// rst_n synchronous active low clears recording state, then the S_CLR pass clears all slots
module linear_probe_list_table_top import lpl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_list_id,
  input  logic [15:0] in_mode,
  input  logic [15:0] in_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_error,
  output logic        out_found,
  output logic        out_accepted,
  output logic [7:0]  out_slot_index,
  output logic [8:0]  out_deleted_count,
  output logic        out_is_recording
);
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  slot_t            ram_rdata;
  logic             res_ok;
  logic             res_valid;
  res_t             res;
  logic             out_valid_r;
  res_t             out_r;

  lpl_key_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lpl_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_list_id (in_list_id),
    .in_mode    (in_mode),
    .in_count   (in_count),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_ok     (res_ok),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign res_ok = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ok) begin
      out_valid_r <= 1'b1;
      out_r       <= res;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_error         = out_r.error;
  assign out_found         = out_r.found;
  assign out_accepted      = out_r.accepted;
  assign out_slot_index    = out_r.slot_index;
  assign out_deleted_count = out_r.deleted_count;
  assign out_is_recording  = out_r.is_recording;
endmodule

[sv/lpl_key_ram.sv]
// slot storage (flags and key), one write and one registered read port
module lpl_key_ram import lpl_pkg::*; (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  slot_t            wdata,
  input  logic [IDX_W-1:0] raddr,
  output slot_t            rdata
);
  slot_t mem_r [TABLE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

[sv/lpl_engine.sv]
// probe sequencer with recording state
`include "linear_probe_list_table_top_macros.svh"
module lpl_engine import lpl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_cmd,
  input  logic [31:0]      in_list_id,
  input  logic [15:0]      in_mode,
  input  logic [15:0]      in_count,
  output logic             ram_we,
  output logic [IDX_W-1:0] ram_waddr,
  output slot_t            ram_wdata,
  output logic [IDX_W-1:0] ram_raddr,
  input  slot_t            ram_rdata,
  input  logic             res_ok,
  output logic             res_valid,
  output res_t             res
);
  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RD, S_CHK, S_FIN} state_t;

  state_t           state_r;
  logic [2:0]       cmd_r;
  logic [31:0]      id_r;
  logic [14:0]      cnt_r;
  logic [IDX_W-1:0] pos_r;
  logic [IDX_W-1:0] n_r;
  logic             free_vld_r;
  logic [IDX_W-1:0] free_r;
  logic [2:0]       err_r;
  logic             found_r;
  logic             acc_r;
  logic [IDX_W-1:0] slot_r;
  logic [IDX_W:0]   del_r;
  logic             rec_r;
  logic [IDX_W-1:0] rec_slot_r;
  logic [15:0]      rec_cnt_r;
  logic             we_r;
  logic [IDX_W-1:0] wa_r;
  slot_t            wd_r;

  logic             cur_used;
  logic             cur_tomb;
  logic             match;
  logic             last;
  logic             del_hit;
  logic             can_claim;
  logic [IDX_W-1:0] claim_slot;
  logic [31:0]      key_diff;

  assign cur_used   = ram_rdata.used;
  assign cur_tomb   = ram_rdata.tomb;
  assign match      = cur_used && (ram_rdata.key == id_r);
  assign last       = (n_r == IDX_W'(TABLE_SLOTS - 1));
  assign key_diff   = ram_rdata.key - id_r;
  assign del_hit    = cur_used && (key_diff < {17'd0, cnt_r});
  assign can_claim  = match || (last && (free_vld_r || !cur_used));
  assign claim_slot = match ? pos_r : (free_vld_r ? free_r : pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      n_r        <= '0;
      rec_r      <= 1'b0;
      rec_slot_r <= '0;
      rec_cnt_r  <= '0;
      we_r       <= 1'b0;
    end else begin
      we_r <= 1'b0;
      unique case (state_r)
        S_CLR: begin
          we_r <= 1'b1;
          wa_r <= n_r;
          wd_r <= '0;
          n_r  <= n_r + IDX_W'(1);
          if (last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r      <= in_cmd;
            id_r       <= in_list_id;
            cnt_r      <= in_count[14:0];
            pos_r      <= (in_cmd == CMD_DELETE) ? '0 : in_list_id[IDX_W-1:0];
            n_r        <= '0;
            free_vld_r <= 1'b0;
            err_r      <= ERR_NONE;
            found_r    <= 1'b0;
            acc_r      <= 1'b0;
            slot_r     <= '0;
            del_r      <= '0;
            state_r    <= S_FIN;
            unique case (in_cmd)
              CMD_NEW: begin
                if (in_list_id == 32'd0) begin
                  err_r <= ERR_VALUE;
                end else if (rec_r) begin
                  err_r <= ERR_OPERATION;
                end else if (in_mode != MODE_COMPILE && in_mode != MODE_COMPILE_EXEC) begin
                  err_r <= ERR_ENUM;
                end else begin
                  state_r <= S_RD;
                end
              end
              CMD_END: begin
                if (!rec_r) begin
                  err_r <= ERR_OPERATION;
                end else begin
                  rec_r      <= 1'b0;
                  rec_slot_r <= '0;
                end
              end
              CMD_CALL: begin
                if (in_list_id == 32'd0) begin
                  err_r <= ERR_VALUE;
                end else begin
                  state_r <= S_RD;
                end
              end
              CMD_DELETE: begin
                if (in_count[15]) begin
                  err_r <= ERR_VALUE;
                end else begin
                  state_r <= S_RD;
                end
              end
              CMD_IS: begin
                if (in_list_id != 32'd0) begin
                  state_r <= S_RD;
                end
              end
              CMD_RECORD: begin
                if (rec_r && rec_cnt_r != MAX_COMMANDS) begin
                  rec_cnt_r <= rec_cnt_r + 16'd1;
                  acc_r     <= 1'b1;
                  slot_r    <= rec_slot_r;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          state_r <= S_RD;
          pos_r   <= pos_r + IDX_W'(1);
          n_r     <= n_r + IDX_W'(1);
          unique case (cmd_r)
            CMD_DELETE: begin
              if (del_hit) begin
                we_r  <= 1'b1;
                wa_r  <= pos_r;
                wd_r  <= '{tomb: 1'b1, used: 1'b0, key: 32'd0};
                del_r <= del_r + (IDX_W+1)'(1);
                if (rec_r && rec_slot_r == pos_r) begin
                  rec_cnt_r <= '0;
                end
              end
              if (last) begin
                state_r <= S_FIN;
              end
            end
            CMD_NEW: begin
              if (can_claim) begin
                we_r       <= 1'b1;
                wa_r       <= claim_slot;
                wd_r       <= '{tomb: 1'b0, used: 1'b1, key: id_r};
                rec_r      <= 1'b1;
                rec_slot_r <= claim_slot;
                rec_cnt_r  <= '0;
                slot_r     <= claim_slot;
                state_r    <= S_FIN;
              end else if (last) begin
                err_r   <= ERR_MEMORY;
                state_r <= S_FIN;
              end else if (!cur_used && !free_vld_r) begin
                free_vld_r <= 1'b1;
                free_r     <= pos_r;
              end
            end
            default: begin
              if (match) begin
                found_r <= 1'b1;
                slot_r  <= pos_r;
                state_r <= S_FIN;
              end else if ((!cur_used && !cur_tomb) || last) begin
                if (cmd_r == CMD_CALL) begin
                  err_r <= ERR_VALUE;
                end
                state_r <= S_FIN;
              end
            end
          endcase
        end
        S_FIN: begin
          if (res_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign ram_raddr = pos_r;
  assign ram_we    = we_r;
  assign ram_waddr = wa_r;
  assign ram_wdata = wd_r;
  assign res_valid = (state_r == S_FIN);
  assign res = '{error: err_r, found: found_r, accepted: acc_r, slot_index: slot_r,
                 deleted_count: del_r, is_recording: rec_r};

  `LPL_ASSERT_NEXT(busy_after_transfer, in_valid && in_ready, !in_ready)
  `LPL_ASSERT_NOW(no_found_and_accepted, res_valid, !(res.found && res.accepted))
  `LPL_ASSERT_NOW(no_write_in_check, ram_we, state_r != S_CHK)
  `LPL_ASSERT_NEXT(claim_writes_slot, state_r == S_CHK && cmd_r == CMD_NEW && can_claim,
                   ram_we && ram_waddr == rec_slot_r && err_r == ERR_NONE)
endmodule

[test/linear_probe_list_table_top_tb.sv]
// self-checking testbench for the linear probing list table
module linear_probe_list_table_top_tb import lpl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;
  localparam int NUM_ITEMS = 1550;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_cmd = '0;
  logic [31:0] in_list_id = '0;
  logic [15:0] in_mode = '0;
  logic [15:0] in_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_error;
  logic out_found;
  logic out_accepted;
  logic [7:0] out_slot_index;
  logic [8:0] out_deleted_count;
  logic out_is_recording;

  linear_probe_list_table_top u_dut (.*);

  always #6 clk = ~clk;

  // table model
  logic [31:0] tbl_key [TABLE_SLOTS];
  logic tbl_used [TABLE_SLOTS];
  logic tbl_tomb [TABLE_SLOTS];
  logic [15:0] tbl_cmds [TABLE_SLOTS];
  logic rec_on;
  logic [7:0] rec_slot;

  res_t pending_results[$];
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int oom_seen = 0;
  int sat_seen = 0;
  bit no_idle = 1'b0;
  int quiet_cycles = 0;

  function automatic res_t mk(logic [2:0] e, int f, int a, int s, int d, int r);
    res_t x;
    x.error = e; x.found = f[0]; x.accepted = a[0];
    x.slot_index = s[7:0]; x.deleted_count = d[8:0]; x.is_recording = r[0];
    return x;
  endfunction

  function automatic int find_slot(logic [31:0] key);
    int pos;
    pos = key % TABLE_SLOTS;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (tbl_used[pos] && tbl_key[pos] == key) return pos;
      if (!tbl_used[pos] && !tbl_tomb[pos]) return -1;
      pos = (pos + 1) % TABLE_SLOTS;
    end
    return -1;
  endfunction

  function automatic int claim_slot(logic [31:0] key);
    int pos;
    int first_free;
    pos = key % TABLE_SLOTS;
    first_free = -1;
    for (int n = 0; n < TABLE_SLOTS; n++) begin
      if (tbl_used[pos] && tbl_key[pos] == key) return pos;
      if (!tbl_used[pos] && first_free < 0) first_free = pos;
      pos = (pos + 1) % TABLE_SLOTS;
    end
    return first_free;
  endfunction

  function automatic res_t table_step(logic [2:0] cmd, logic [31:0] id,
                                      logic [15:0] mode, logic [15:0] cnt);
    res_t r;
    int s;
    logic [31:0] diff;
    r = '0;
    case (cmd)
      CMD_NEW: begin
        if (id == 0) r.error = ERR_VALUE;
        else if (rec_on) r.error = ERR_OPERATION;
        else if (mode != MODE_COMPILE && mode != MODE_COMPILE_EXEC) r.error = ERR_ENUM;
        else begin
          s = claim_slot(id);
          if (s < 0) begin
            r.error = ERR_MEMORY;
            oom_seen++;
          end else begin
            r.slot_index = s[7:0];
            tbl_key[s] = id; tbl_used[s] = 1'b1; tbl_tomb[s] = 1'b0; tbl_cmds[s] = '0;
            rec_on = 1'b1; rec_slot = s[7:0];
          end
        end
      end
      CMD_END: begin
        if (!rec_on) r.error = ERR_OPERATION;
        else begin
          rec_on = 1'b0; rec_slot = '0;
        end
      end
      CMD_CALL, CMD_IS: begin
        s = (id == 0) ? -1 : find_slot(id);
        if (s >= 0) begin
          r.found = 1'b1; r.slot_index = s[7:0];
        end else if (cmd == CMD_CALL) r.error = ERR_VALUE;
      end
      CMD_DELETE: begin
        if (cnt[15]) r.error = ERR_VALUE;
        else begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            diff = tbl_key[i] - id;
            if (tbl_used[i] && diff < {16'd0, cnt}) begin
              tbl_used[i] = 1'b0; tbl_tomb[i] = 1'b1; tbl_key[i] = '0; tbl_cmds[i] = '0;
              r.deleted_count++;
            end
          end
        end
      end
      CMD_RECORD: begin
        if (rec_on && tbl_cmds[rec_slot] != MAX_COMMANDS) begin
          tbl_cmds[rec_slot]++;
          r.accepted = 1'b1; r.slot_index = rec_slot;
        end else if (rec_on) sat_seen++;
      end
      default: ;
    endcase
    r.is_recording = rec_on;
    return r;
  endfunction

  // one input transfer; typed expectation overrides the model's when given
  task automatic send(logic [2:0] cmd, logic [31:0] id, logic [15:0] mode,
                      logic [15:0] cnt, bit typed = 0, res_t typed_res = '0);
    int gap;
    res_t r;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd; in_list_id <= id; in_mode <= mode; in_count <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = table_step(cmd, id, mode, cnt);
    pending_results.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  // result side
  always @(posedge clk) begin
    automatic res_t got;
    automatic res_t want;
    if (rst_n && out_valid && out_ready) begin
      got = mk(out_error, out_found, out_accepted, out_slot_index,
               out_deleted_count, out_is_recording);
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.error !== want.error) begin
          $display("%0t: error exp %0d got %0d", $time, want.error, got.error); errors++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found exp %0d got %0d", $time, want.found, got.found); errors++;
        end
        if (got.accepted !== want.accepted) begin
          $display("%0t: accepted exp %0d got %0d", $time, want.accepted, got.accepted);
          errors++;
        end
        if (got.slot_index !== want.slot_index) begin
          $display("%0t: slot_index exp %0d got %0d", $time, want.slot_index,
                   got.slot_index);
          errors++;
        end
        if (got.deleted_count !== want.deleted_count) begin
          $display("%0t: deleted_count exp %0d got %0d", $time, want.deleted_count,
                   got.deleted_count);
          errors++;
        end
        if (got.is_recording !== want.is_recording) begin
          $display("%0t: is_recording exp %0d got %0d", $time, want.is_recording,
                   got.is_recording);
          errors++;
        end
      end
    end
  end

  // result stall generator
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 14);
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_key();
    logic [31:0] bases [4] = '{32'h0, 32'h100, 32'hFFFF_FF00, 32'h00AB_CD00};
    if ($urandom_range(0, 4) == 0) return $urandom;
    return bases[$urandom_range(0, 3)] | $urandom_range(0, 15);
  endfunction

  function automatic logic [15:0] pick_mode();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1, 2: return MODE_COMPILE;
      default: return MODE_COMPILE_EXEC;
    endcase
  endfunction

  typedef struct {
    logic [2:0] cmd;
    logic [31:0] id;
    logic [15:0] mode;
    logic [15:0] cnt;
    bit typed;
    res_t res;
  } stim_row_t;

  stim_row_t directed [24];

  initial begin
    logic [31:0] key;
    int nrec;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_key[i] = '0; tbl_used[i] = 1'b0; tbl_tomb[i] = 1'b0; tbl_cmds[i] = '0;
    end
    rec_on = 1'b0; rec_slot = '0;

    directed = '{
      '{CMD_END, 32'd0, 16'd0, 16'd0, 1, mk(ERR_OPERATION, 0, 0, 0, 0, 0)},
      '{CMD_RECORD, 32'd0, 16'd0, 16'd0, 1, mk(ERR_NONE, 0, 0, 0, 0, 0)},
      '{CMD_CALL, 32'd0, 16'd0, 16'd0, 1, mk(ERR_VALUE, 0, 0, 0, 0, 0)},
      '{CMD_IS, 32'd0, 16'd0, 16'd0, 1, mk(ERR_NONE, 0, 0, 0, 0, 0)},
      '{CMD_DELETE, 32'd1, 16'd0, 16'h8000, 1, mk(ERR_VALUE, 0, 0, 0, 0, 0)},
      '{CMD_NEW, 32'd0, MODE_COMPILE, 16'd0, 1, mk(ERR_VALUE, 0, 0, 0, 0, 0)},
      '{CMD_NEW, 32'd5, 16'hFFFF, 16'd0, 1, mk(ERR_ENUM, 0, 0, 0, 0, 0)},
      '{CMD_SPARE_A, 32'd5, MODE_COMPILE, 16'd1, 1, mk(ERR_NONE, 0, 0, 0, 0, 0)},
      '{CMD_SPARE_B, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, mk(ERR_NONE, 0, 0, 0, 0, 0)},
      '{CMD_NEW, 32'd5, MODE_COMPILE, 16'd0, 1, mk(ERR_NONE, 0, 0, 5, 0, 1)},
      '{CMD_NEW, 32'd9, MODE_COMPILE, 16'd0, 1, mk(ERR_OPERATION, 0, 0, 0, 0, 1)},
      '{CMD_RECORD, 32'd0, 16'd0, 16'd0, 1, mk(ERR_NONE, 0, 1, 5, 0, 1)},
      '{CMD_END, 32'd0, 16'd0, 16'd0, 1, mk(ERR_NONE, 0, 0, 0, 0, 0)},
      '{CMD_IS, 32'd5, 16'd0, 16'd0, 1, mk(ERR_NONE, 1, 0, 5, 0, 0)},
      '{CMD_CALL, 32'hFFFF_FFFF, 16'd0, 16'd0, 1, mk(ERR_VALUE, 0, 0, 0, 0, 0)},
      '{CMD_NEW, 32'hFFFF_FFFF, MODE_COMPILE_EXEC, 16'd0, 1, mk(ERR_NONE, 0, 0, 255, 0, 1)},
      '{CMD_RECORD, 32'd0, 16'd0, 16'd0, 1, mk(ERR_NONE, 0, 1, 255, 0, 1)},
      '{CMD_DELETE, 32'hFFFF_FFFF, 16'd0, 16'd7, 1, mk(ERR_NONE, 0, 0, 0, 2, 1)},
      '{CMD_RECORD, 32'd0, 16'd0, 16'd0, 0, '0},
      '{CMD_END, 32'd0, 16'd0, 16'd0, 0, '0},
      '{CMD_NEW, 32'h105, MODE_COMPILE, 16'd0, 0, '0},
      '{CMD_END, 32'd0, 16'd0, 16'd0, 0, '0},
      '{CMD_IS, 32'd5, 16'd0, 16'd0, 0, '0},
      '{CMD_DELETE, 32'd0, 16'd0, 16'h7FFF, 0, '0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send(directed[i].cmd, directed[i].id, directed[i].mode, directed[i].cnt,
           directed[i].typed, directed[i].res);

    // fill the table until it runs out of slots, then clear it
    for (int i = 0; i < 258; i++) begin
      send(CMD_NEW, 32'h1000_0000 + i * 7, MODE_COMPILE, 16'd0);
      send(CMD_END, 32'd0, 16'd0, 16'd0);
    end
    send(CMD_IS, 32'h1000_0000 + 7 * 100, 16'd0, 16'd0);
    send(CMD_DELETE, 32'h1000_0000, 16'd0, 16'd1000);
    send(CMD_DELETE, 32'h1000_03E8, 16'd0, 16'h7FFF);

    while (items_sent < NUM_ITEMS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          key = pick_key();
          send(CMD_NEW, key, pick_mode(), 16'($urandom));
          nrec = $urandom_range(0, 4);
          repeat (nrec) send(CMD_RECORD, $urandom, 16'($urandom), 16'($urandom));
          if ($urandom_range(0, 5) != 0)
            send(CMD_END, $urandom, 16'($urandom), 16'($urandom));
        end
        4, 5: send($urandom_range(0, 1) ? CMD_CALL : CMD_IS, pick_key(), 16'($urandom),
                   16'($urandom));
        6: begin
          key = pick_key();
          send(CMD_DELETE, key - $urandom_range(0, 3), 16'($urandom),
               ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20)));
        end
        7: send(3'($urandom), $urandom, 16'($urandom), 16'($urandom));
        8: send(CMD_RECORD, $urandom, 16'($urandom), 16'($urandom));
        default: send(CMD_END, $urandom, 16'($urandom), 16'($urandom));
      endcase
    end

    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("covered %0d items and %0d results, %0d out-of-slot claims,", items_sent,
             results_seen, oom_seen);
    $display("%0d saturated records, probe chains, tombstones and range deletes", sat_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
